// ===== design/pfc_pkg.sv =====
package pfc_pkg;

    localparam int FRAMES_DEFAULT = 16;

    // Result status codes.
    localparam logic [2:0] STAT_HIT       = 3'd0;
    localparam logic [2:0] STAT_MISS_FREE = 3'd1;
    localparam logic [2:0] STAT_MISS_EVICT = 3'd2;
    localparam logic [2:0] STAT_REJECTED  = 3'd3;
    localparam logic [2:0] STAT_INSTALLED = 3'd4;
    localparam logic [2:0] STAT_FILL_FAIL = 3'd5;

    // Policy codes.
    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_LFU   = 2'd2;
    localparam logic [1:0] POL_CLOCK = 2'd3;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_VREAD
    } state_t;

    // One frame table entry as held in the memory.
    typedef struct packed {
        logic [15:0] proc_id;
        logic [19:0] page;
        logic [31:0] loaded_at;
        logic [31:0] used_at;
        logic [31:0] uses;
    } entry_t;

endpackage

// ===== design/page_frame_cache_replacement.sv =====
// A fill or a rejected access shows its result word in the cycle after acceptance.
// An access scans the frame memory one entry a cycle and then shows its result; a
// clock eviction adds a sweep of the reference bits and then a victim read.
// Throughput: one item in flight; the next word is taken the cycle after the result leaves.
// Reset (aresetn low, synchronous) clears valid and reference bits, counters, hand and
// pending miss; the policy resets to clock. Entry tags are undefined until written.
module page_frame_cache_replacement #(
    parameter int FRAMES = pfc_pkg::FRAMES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_proc_id,
    input  logic [31:0] s_vaddr,
    input  logic        s_writeback_ok,
    input  logic        s_source_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot,
    output logic [15:0] m_victim_proc,
    output logic [19:0] m_victim_page,
    output logic [31:0] m_hit_total,
    output logic [31:0] m_miss_total
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

    pfc_pkg::state_t state_reg, state_next;
    logic [1:0]        policy_reg, policy_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] ref_reg, ref_next;
    logic [IW-1:0]     hand_reg, hand_next;
    logic [31:0]       time_reg, time_next;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       misses_reg, misses_next;
    logic [IW-1:0]     pend_slot_reg, pend_slot_next;
    logic [15:0]       pend_proc_reg, pend_proc_next;
    logic [19:0]       pend_page_reg, pend_page_next;
    logic              pend_live_reg, pend_live_next;
    logic              pend_evict_reg, pend_evict_next;
    logic [15:0]       req_proc_reg, req_proc_next;
    logic [19:0]       req_page_reg, req_page_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              dv_reg, dv_next;
    logic [IW-1:0]     didx_reg, didx_next;
    logic              fnd_reg, fnd_next;
    logic [IW-1:0]     fnd_idx_reg, fnd_idx_next;
    pfc_pkg::entry_t   fnd_ent_reg, fnd_ent_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [31:0]       min_val_reg, min_val_next;
    logic [IW-1:0]     min_idx_reg, min_idx_next;
    pfc_pkg::entry_t   min_ent_reg, min_ent_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [3:0]        m_slot_reg, m_slot_next;
    logic [15:0]       m_vproc_reg, m_vproc_next;
    logic [19:0]       m_vpage_reg, m_vpage_next;
    logic [31:0]       m_hits_reg, m_hits_next;
    logic [31:0]       m_misses_reg, m_misses_next;

    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    pfc_pkg::entry_t   wr_data, rd_data;

    pfc_frame_mem #(.FRAMES(FRAMES), .IW(IW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready       = (state_reg == pfc_pkg::ST_IDLE) && !m_valid_reg;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_victim_proc = m_vproc_reg;
    assign m_victim_page = m_vpage_reg;
    assign m_hit_total   = m_hits_reg;
    assign m_miss_total  = m_misses_reg;

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfc_pkg::ST_IDLE;
            policy_reg     <= pfc_pkg::POL_CLOCK;
            valid_reg      <= '0;
            ref_reg        <= '0;
            hand_reg       <= '0;
            time_reg       <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            pend_slot_reg  <= '0;
            pend_proc_reg  <= '0;
            pend_page_reg  <= '0;
            pend_live_reg  <= 1'b0;
            pend_evict_reg <= 1'b0;
            cnt_reg        <= '0;
            dv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            valid_reg      <= valid_next;
            ref_reg        <= ref_next;
            hand_reg       <= hand_next;
            time_reg       <= time_next;
            hits_reg       <= hits_next;
            misses_reg     <= misses_next;
            pend_slot_reg  <= pend_slot_next;
            pend_proc_reg  <= pend_proc_next;
            pend_page_reg  <= pend_page_next;
            pend_live_reg  <= pend_live_next;
            pend_evict_reg <= pend_evict_next;
            cnt_reg        <= cnt_next;
            dv_reg         <= dv_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_proc_reg <= req_proc_next;
        req_page_reg <= req_page_next;
        didx_reg     <= didx_next;
        fnd_reg      <= fnd_next;
        fnd_idx_reg  <= fnd_idx_next;
        fnd_ent_reg  <= fnd_ent_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        min_val_reg  <= min_val_next;
        min_idx_reg  <= min_idx_next;
        min_ent_reg  <= min_ent_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_vproc_reg  <= m_vproc_next;
        m_vpage_reg  <= m_vpage_next;
        m_hits_reg   <= m_hits_next;
        m_misses_reg <= m_misses_next;
    end

    // Sequencer: fill, rejection, scan, clock sweep and victim read.
    always_comb begin
        logic        cur_v;
        logic        cur_m;
        logic [31:0] pv;
        logic        take;
        logic [31:0] t1;

        state_next      = state_reg;
        policy_next     = cfg_wr_en ? cfg_wr_data : policy_reg;
        valid_next      = valid_reg;
        ref_next        = ref_reg;
        hand_next       = hand_reg;
        time_next       = time_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        pend_slot_next  = pend_slot_reg;
        pend_proc_next  = pend_proc_reg;
        pend_page_next  = pend_page_reg;
        pend_live_next  = pend_live_reg;
        pend_evict_next = pend_evict_reg;
        req_proc_next   = req_proc_reg;
        req_page_next   = req_page_reg;
        cnt_next        = cnt_reg;
        dv_next         = 1'b0;
        didx_next       = didx_reg;
        fnd_next        = fnd_reg;
        fnd_idx_next    = fnd_idx_reg;
        fnd_ent_next    = fnd_ent_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        min_val_next    = min_val_reg;
        min_idx_next    = min_idx_reg;
        min_ent_next    = min_ent_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_vproc_next    = m_vproc_reg;
        m_vpage_next    = m_vpage_reg;
        m_hits_next     = m_hits_reg;
        m_misses_next   = m_misses_reg;
        wr_en           = 1'b0;
        wr_addr         = pend_slot_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[IW-1:0];
        t1              = time_reg + 32'd1;

        // Evaluation of the entry read in the previous cycle.
        cur_v = valid_reg[didx_reg];
        cur_m = cur_v && (rd_data.proc_id == req_proc_reg) && (rd_data.page == req_page_reg);
        unique case (policy_reg)
            pfc_pkg::POL_FIFO: pv = rd_data.loaded_at;
            pfc_pkg::POL_LRU:  pv = rd_data.used_at;
            default:           pv = rd_data.uses;
        endcase
        take = (didx_reg == '0) || (pv < min_val_reg);

        unique case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    pend_live_next = 1'b0;
                    m_vproc_next   = '0;
                    m_vpage_next   = '0;
                    m_hits_next    = hits_reg;
                    m_misses_next  = misses_reg;
                    if (s_opcode == pfc_pkg::OP_FILL) begin
                        m_valid_next  = 1'b1;
                        m_slot_next   = pend_live_reg ? 4'(pend_slot_reg) : 4'd0;
                        m_status_next = pfc_pkg::STAT_FILL_FAIL;
                        if (pend_live_reg && s_source_ok &&
                            (s_writeback_ok || !pend_evict_reg)) begin
                            m_status_next = pfc_pkg::STAT_INSTALLED;
                            time_next     = t1;
                            wr_en         = 1'b1;
                            wr_data       = '{proc_id: pend_proc_reg, page: pend_page_reg,
                                              loaded_at: t1, used_at: t1, uses: 32'd1};
                            valid_next[pend_slot_reg] = 1'b1;
                            ref_next[pend_slot_reg]   = 1'b1;
                        end
                    end else if (s_vaddr[31]) begin
                        m_valid_next  = 1'b1;
                        m_status_next = pfc_pkg::STAT_REJECTED;
                        m_slot_next   = 4'd0;
                    end else begin
                        req_proc_next = s_proc_id;
                        req_page_next = s_vaddr[31:12];
                        cnt_next      = '0;
                        fnd_next      = 1'b0;
                        free_next     = 1'b0;
                        state_next    = pfc_pkg::ST_SCAN;
                    end
                end
            end
            pfc_pkg::ST_SCAN: begin
                // Issue the next read while the previous one is evaluated.
                if (cnt_reg < CW'(FRAMES)) begin
                    rd_en     = 1'b1;
                    rd_addr   = cnt_reg[IW-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                    dv_next   = 1'b1;
                    didx_next = cnt_reg[IW-1:0];
                end
                if (dv_reg) begin
                    if (!fnd_reg && cur_m) begin
                        fnd_next     = 1'b1;
                        fnd_idx_next = didx_reg;
                        fnd_ent_next = rd_data;
                    end
                    if (!free_reg && !cur_v) begin
                        free_next     = 1'b1;
                        free_idx_next = didx_reg;
                    end
                    if (take) begin
                        min_val_next = pv;
                        min_idx_next = didx_reg;
                        min_ent_next = rd_data;
                    end
                    if (didx_reg == LAST) begin
                        state_next = pfc_pkg::ST_IDLE;
                        if (fnd_next) begin
                            time_next     = t1;
                            hits_next     = hits_reg + 32'd1;
                            wr_en         = 1'b1;
                            wr_addr       = fnd_idx_next;
                            wr_data       = fnd_ent_next;
                            wr_data.used_at = t1;
                            wr_data.uses  = fnd_ent_next.uses + 32'd1;
                            ref_next[fnd_idx_next] = 1'b1;
                            m_valid_next  = 1'b1;
                            m_status_next = pfc_pkg::STAT_HIT;
                            m_slot_next   = 4'(fnd_idx_next);
                            m_hits_next   = hits_reg + 32'd1;
                        end else begin
                            misses_next    = misses_reg + 32'd1;
                            m_misses_next  = misses_reg + 32'd1;
                            pend_proc_next = req_proc_reg;
                            pend_page_next = req_page_reg;
                            if (free_next) begin
                                pend_slot_next  = free_idx_next;
                                pend_live_next  = 1'b1;
                                pend_evict_next = 1'b0;
                                m_valid_next    = 1'b1;
                                m_status_next   = pfc_pkg::STAT_MISS_FREE;
                                m_slot_next     = 4'(free_idx_next);
                            end else if (policy_reg != pfc_pkg::POL_CLOCK) begin
                                pend_slot_next  = min_idx_next;
                                pend_live_next  = 1'b1;
                                pend_evict_next = 1'b1;
                                m_valid_next    = 1'b1;
                                m_status_next   = pfc_pkg::STAT_MISS_EVICT;
                                m_slot_next     = 4'(min_idx_next);
                                m_vproc_next    = min_ent_next.proc_id;
                                m_vpage_next    = min_ent_next.page;
                            end else begin
                                state_next = pfc_pkg::ST_SWEEP;
                            end
                        end
                    end
                end
            end
            pfc_pkg::ST_SWEEP: begin
                // Second chance: clear set bits until a clear one is found.
                hand_next = (hand_reg == LAST) ? '0 : hand_reg + 1'b1;
                if (!ref_reg[hand_reg]) begin
                    min_idx_next = hand_reg;
                    rd_en        = 1'b1;
                    rd_addr      = hand_reg;
                    state_next   = pfc_pkg::ST_VREAD;
                end else begin
                    ref_next[hand_reg] = 1'b0;
                end
            end
            pfc_pkg::ST_VREAD: begin
                pend_slot_next  = min_idx_reg;
                pend_live_next  = 1'b1;
                pend_evict_next = 1'b1;
                m_valid_next    = 1'b1;
                m_status_next   = pfc_pkg::STAT_MISS_EVICT;
                m_slot_next     = 4'(min_idx_reg);
                m_vproc_next    = rd_data.proc_id;
                m_vpage_next    = rd_data.page;
                state_next      = pfc_pkg::ST_IDLE;
            end
            default: begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    // A result word is only ever shown once the sequencer is back at rest.
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pfc_pkg::ST_IDLE) |-> !m_valid_reg)
        else $error("result word while item still in work");

    // A fill with nothing pending reports failure at slot zero.
    a_fill_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == pfc_pkg::OP_FILL && !pend_live_reg) |=>
        (m_valid_reg && m_status_reg == pfc_pkg::STAT_FILL_FAIL && m_slot_reg == 4'd0))
        else $error("fill without pending miss misreported");

    // The clock sweep only starts on a full table.
    a_sweep_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfc_pkg::ST_SWEEP) |-> (valid_reg == {FRAMES{1'b1}}))
        else $error("clock sweep with a free frame");

    // A clock eviction always leaves an eviction pending.
    a_evict_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfc_pkg::ST_VREAD) |=> (pend_live_reg && pend_evict_reg))
        else $error("eviction did not record pending miss");

endmodule

// ===== design/pfc_frame_mem.sv =====
module pfc_frame_mem #(
    parameter int FRAMES = pfc_pkg::FRAMES_DEFAULT,
    parameter int IW     = $clog2(FRAMES)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_addr,
    input  pfc_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [IW-1:0]    rd_addr,
    output pfc_pkg::entry_t  rd_data
);

    pfc_pkg::entry_t mem [FRAMES];

    // Single write port, single registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== test/tb_page_frame_cache_replacement.sv =====
module tb_page_frame_cache_replacement;

    localparam int NSLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    // One input word and one result word.
    typedef struct {
        logic        opcode;
        logic [15:0] proc_id;
        logic [31:0] vaddr;
        logic        writeback_ok;
        logic        source_ok;
    } access_word_t;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] victim_proc;
        logic [19:0] victim_page;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } outcome_word_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = pfc_pkg::OP_ACCESS;
    logic [15:0] s_proc_id = '0;
    logic [31:0] s_vaddr = '0;
    logic        s_writeback_ok = 1'b0;
    logic        s_source_ok = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_slot;
    logic [15:0] m_victim_proc;
    logic [19:0] m_victim_page;
    logic [31:0] m_hit_total;
    logic [31:0] m_miss_total;

    page_frame_cache_replacement dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_proc_id     (s_proc_id),
        .s_vaddr       (s_vaddr),
        .s_writeback_ok(s_writeback_ok),
        .s_source_ok   (s_source_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_victim_proc (m_victim_proc),
        .m_victim_page (m_victim_page),
        .m_hit_total   (m_hit_total),
        .m_miss_total  (m_miss_total)
    );

    // Shadow copy of the frame table.
    logic [1:0]  shadow_policy;
    logic        tbl_valid [NSLOTS];
    logic [15:0] tbl_proc [NSLOTS];
    logic [19:0] tbl_page [NSLOTS];
    logic [31:0] tbl_loaded [NSLOTS];
    logic [31:0] tbl_used [NSLOTS];
    logic [31:0] tbl_uses [NSLOTS];
    logic        tbl_ref [NSLOTS];
    logic [3:0]  hand;
    logic [31:0] now_tick;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [3:0]  pend_slot;
    logic [15:0] pend_proc;
    logic [19:0] pend_page;
    logic        pend_live;
    logic        pend_evict;

    access_word_t  pending_words [$];
    outcome_word_t expected_outcomes [$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  long_hold;
    int  hold_count = 0;
    bit  failed = 1'b0;
    int  quiet_cycles = 0;

    // Acceptance flag registered at the rising edge for the driver to see.
    logic s_ready_seen = 1'b0;

    // Page numbers installed so far (some may since be evicted), used to steer random accesses toward hits.
    logic [15:0] known_proc [$];
    logic [19:0] known_page [$];

    // Clock generation.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int lowest_of(input logic [31:0] vals [NSLOTS]);
        int best;
        best = 0;
        for (int i = 1; i < NSLOTS; i++) begin
            if (vals[i] < vals[best]) begin
                best = i;
            end
        end
        return best;
    endfunction

    task automatic reset_shadow();
        shadow_policy = pfc_pkg::POL_CLOCK;
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_proc[i] = '0;
            tbl_page[i] = '0;
            tbl_loaded[i] = '0;
            tbl_used[i] = '0;
            tbl_uses[i] = '0;
            tbl_ref[i] = 1'b0;
        end
        hand = '0;
        now_tick = '0;
        hit_count = '0;
        miss_count = '0;
        pend_slot = '0;
        pend_proc = '0;
        pend_page = '0;
        pend_live = 1'b0;
        pend_evict = 1'b0;
    endtask

    // Choose a victim slot under the current policy; the clock sweep updates state.
    function automatic int choose_victim();
        int h;
        case (shadow_policy)
            pfc_pkg::POL_FIFO: begin
                return lowest_of(tbl_loaded);
            end
            pfc_pkg::POL_LRU: begin
                return lowest_of(tbl_used);
            end
            pfc_pkg::POL_LFU: begin
                return lowest_of(tbl_uses);
            end
            default: begin
                for (int n = 0; n <= NSLOTS; n++) begin
                    h = int'(hand);
                    hand = hand + 4'd1;
                    if (!tbl_ref[h]) begin
                        return h;
                    end
                    tbl_ref[h] = 1'b0;
                end
                return int'(hand);
            end
        endcase
    endfunction

    // Work out the result of one accepted word and queue it.
    task automatic predict_cache(input access_word_t w);
        outcome_word_t r;
        logic [19:0] pg;
        int found;
        int freei;
        r = '{default: '0};
        if (w.opcode == pfc_pkg::OP_FILL) begin
            if (!pend_live) begin
                r.status = pfc_pkg::STAT_FILL_FAIL;
            end else begin
                r.slot = pend_slot;
                if (w.source_ok && (w.writeback_ok || !pend_evict)) begin
                    now_tick = now_tick + 32'd1;
                    tbl_valid[pend_slot] = 1'b1;
                    tbl_proc[pend_slot] = pend_proc;
                    tbl_page[pend_slot] = pend_page;
                    tbl_loaded[pend_slot] = now_tick;
                    tbl_used[pend_slot] = now_tick;
                    tbl_uses[pend_slot] = 32'd1;
                    tbl_ref[pend_slot] = 1'b1;
                    known_proc.push_back(pend_proc);
                    known_page.push_back(pend_page);
                    r.status = pfc_pkg::STAT_INSTALLED;
                end else begin
                    r.status = pfc_pkg::STAT_FILL_FAIL;
                end
                pend_live = 1'b0;
            end
        end else begin
            pg = w.vaddr[31:12];
            pend_live = 1'b0;
            if (w.vaddr[31]) begin
                r.status = pfc_pkg::STAT_REJECTED;
            end else begin
                found = -1;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (found < 0 && tbl_valid[i] && tbl_proc[i] == w.proc_id
                        && tbl_page[i] == pg) begin
                        found = i;
                    end
                end
                if (found >= 0) begin
                    now_tick = now_tick + 32'd1;
                    hit_count = hit_count + 32'd1;
                    tbl_used[found] = now_tick;
                    tbl_uses[found] = tbl_uses[found] + 32'd1;
                    tbl_ref[found] = 1'b1;
                    r.status = pfc_pkg::STAT_HIT;
                    r.slot = 4'(found);
                end else begin
                    miss_count = miss_count + 32'd1;
                    freei = -1;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (freei < 0 && !tbl_valid[i]) begin
                            freei = i;
                        end
                    end
                    if (freei >= 0) begin
                        r.status = pfc_pkg::STAT_MISS_FREE;
                        pend_evict = 1'b0;
                    end else begin
                        freei = choose_victim();
                        r.status = pfc_pkg::STAT_MISS_EVICT;
                        r.victim_proc = tbl_proc[freei];
                        r.victim_page = tbl_page[freei];
                        pend_evict = 1'b1;
                    end
                    r.slot = 4'(freei);
                    pend_slot = 4'(freei);
                    pend_proc = w.proc_id;
                    pend_page = pg;
                    pend_live = 1'b1;
                end
            end
        end
        r.hit_total = hit_count;
        r.miss_total = miss_count;
        expected_outcomes.push_back(r);
    endtask

    function automatic access_word_t make_access(input logic [15:0] p, input logic [31:0] va);
        access_word_t w;
        w.opcode = pfc_pkg::OP_ACCESS;
        w.proc_id = p;
        w.vaddr = va;
        w.writeback_ok = 1'($urandom_range(0, 1));
        w.source_ok = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic access_word_t make_fill(input logic wb, input logic src);
        access_word_t w;
        w.opcode = pfc_pkg::OP_FILL;
        w.proc_id = 16'($urandom);
        w.vaddr = $urandom;
        w.writeback_ok = wb;
        w.source_ok = src;
        return w;
    endfunction

    // Random traffic: mostly miss-then-fill pairs and reaccesses, some noise.
    task automatic queue_random(input int count);
        int k;
        int sel;
        logic [15:0] p;
        logic [31:0] va;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40 && known_proc.size() > 0) begin
                k = $urandom_range(0, known_proc.size() - 1);
                va = {known_page[k], 12'(($urandom))};
                pending_words.push_back(make_access(known_proc[k], va));
            end else if (sel < 85) begin
                p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
                va = ($urandom_range(0, 9) == 0) ? {1'b0, 31'($urandom)}
                                                 : {12'd0, 8'($urandom_range(0, 40)),
                                                    12'($urandom)};
                pending_words.push_back(make_access(p, va));
                if ($urandom_range(0, 9) != 0) begin
                    pending_words.push_back(make_fill($urandom_range(0, 7) != 0,
                                                      $urandom_range(0, 7) != 0));
                end
            end else if (sel < 92) begin
                pending_words.push_back(make_access(16'($urandom), {1'b1, 31'($urandom)}));
            end else begin
                pending_words.push_back(make_fill(1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))));
            end
        end
    endtask

    // Driver: offers queued words, changing inputs on the falling edge.
    always @(negedge aclk) begin
        access_word_t w;
        if (s_valid && !s_ready_seen) begin
            // hold the current word until accepted
        end else begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_opcode <= w.opcode;
                s_proc_id <= w.proc_id;
                s_vaddr <= w.vaddr;
                s_writeback_ok <= w.writeback_ok;
                s_source_ok <= w.source_ok;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(negedge aclk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge aclk) begin
        outcome_word_t e;
        access_word_t w;
        s_ready_seen <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            w.opcode = s_opcode;
            w.proc_id = s_proc_id;
            w.vaddr = s_vaddr;
            w.writeback_ok = s_writeback_ok;
            w.source_ok = s_source_ok;
            predict_cache(w);
            s_ready_seen <= 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result word with nothing expected: status %0d", m_status);
                failed = 1'b1;
            end else begin
                e = expected_outcomes.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_status);
                    failed = 1'b1;
                end
                if (m_slot !== e.slot) begin
                    $error("slot: expected %0d, actual %0d", e.slot, m_slot);
                    failed = 1'b1;
                end
                if (m_victim_proc !== e.victim_proc) begin
                    $error("victim_proc: expected %h, actual %h", e.victim_proc, m_victim_proc);
                    failed = 1'b1;
                end
                if (m_victim_page !== e.victim_page) begin
                    $error("victim_page: expected %h, actual %h", e.victim_page, m_victim_page);
                    failed = 1'b1;
                end
                if (m_hit_total !== e.hit_total) begin
                    $error("hit_total: expected %0d, actual %0d", e.hit_total, m_hit_total);
                    failed = 1'b1;
                end
                if (m_miss_total !== e.miss_total) begin
                    $error("miss_total: expected %0d, actual %0d", e.miss_total, m_miss_total);
                    failed = 1'b1;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Wait until every queued word went in and every result came back.
    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_outcomes.size() > 0) begin
            @(posedge aclk);
        end
        repeat (2 * NSLOTS + 8) @(posedge aclk);
    endtask

    task automatic write_policy(input logic [1:0] pol);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pol;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_policy = pol;
    endtask

    initial begin
        logic [1:0] policies [6];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = pfc_pkg::POL_CLOCK;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        long_hold = 1'b0;
        reset_shadow();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset policy: fills with nothing pending, extremes,
        // kernel rejection, free fills ignoring writeback, failed fills, hits.
        pending_words.push_back(make_fill(1'b1, 1'b1));
        pending_words.push_back(make_access(16'hFFFF, 32'h7FFF_FFFF));
        pending_words.push_back(make_fill(1'b0, 1'b1));
        pending_words.push_back(make_access(16'hFFFF, 32'h7FFF_F000));
        pending_words.push_back(make_access(16'h0000, 32'h8000_0000));
        pending_words.push_back(make_access(16'hFFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_access(16'h0000, 32'h0000_0000));
        pending_words.push_back(make_fill(1'b1, 1'b0));
        pending_words.push_back(make_access(16'h0000, 32'h0000_0000));
        pending_words.push_back(make_access(16'h0000, 32'h0000_0FFF));
        pending_words.push_back(make_fill(1'b1, 1'b1));
        pending_words.push_back(make_access(16'h0000, 32'h0000_0ABC));
        for (int i = 0; i < 6; i++) begin
            pending_words.push_back(make_access(16'h1234, {12'd0, 8'(i + 1), 12'd0}));
            pending_words.push_back(make_fill(1'b0, 1'b1));
        end
        drain();

        // Random phases under every policy, each with one of four idling patterns.
        policies = '{pfc_pkg::POL_FIFO, pfc_pkg::POL_LRU, pfc_pkg::POL_LFU,
                     pfc_pkg::POL_CLOCK, pfc_pkg::POL_FIFO, pfc_pkg::POL_CLOCK};
        for (int ph = 0; ph < 6; ph++) begin
            write_policy(policies[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            if (ph == 4) begin
                long_hold = 1'b1;
            end
            queue_random(130);
            drain();
        end

        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
